### hdl/fir_conv_pkg.sv
// Shared types and constants for the FIR convolution filter.
// No dependencies; imported by the top level, its checker and the testbench.

package fir_conv_pkg;

    // Beat type codes on the input channel.
    localparam logic REQ_LOAD_COEF = 1'b0;
    localparam logic REQ_SAMPLE    = 1'b1;

    // Configuration register index, carried on paddr[2].
    localparam logic REG_TAP_COUNT = 1'b0;

    // Sample and coefficient format: signed Q1.15.
    localparam int DATA_W    = 16;
    localparam int FRAC_BITS = 15;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int TAP_CNT_W = 9;

    typedef logic signed [DATA_W-1:0] t_sample;
    typedef logic signed [PROD_W-1:0] t_product;

endpackage

### hdl/fir_convolution_filter.sv
// Top level of the FIR convolution filter: sequencer, shared multiply-accumulate unit,
// coefficient and history memories. Depends on fir_conv_pkg and fir_conv_ram.
//
//  Channel    Handshake                  Payload
//  ---------  -------------------------  -------------------------------------------
//  input      i_valid / o_ready          i_req_type, i_coef_index, i_data_value
//  output     o_valid / i_ready          o_filtered_sample
//  config     psel, penable, pwrite      paddr, pwdata, prdata (pready tied high)
//
// A coefficient load leaves the block ready for the next beat.
// After its beat a sample keeps the block busy: one multiply-accumulate per tap through
// the single shared multiplier, a drain of the read and product registers, and a final
// step that rounds, saturates and loads the output register. With tap_count zero the tap
// loop is skipped. After reset a clearing pass zeroes every address of both memories; no
// beat is taken during it. A result still held in the output register stalls only the
// next sample's final step.

module fir_convolution_filter
    import fir_conv_pkg::*;
#(
    parameter int MAX_TAPS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_req_type,
    input  logic [7:0]           i_coef_index,
    input  logic signed [15:0]   i_data_value,
    // Output channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [15:0]   o_filtered_sample,
    // Configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int CW    = $clog2(MAX_TAPS + 1);
    localparam int ACC_W = PROD_W + AW;

    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

    // Sequencer states.
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MAC   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [AW-1:0]          r_clr, n_clr;
    logic [AW-1:0]          r_wp, n_wp;
    logic [AW-1:0]          r_pos, n_pos;
    logic [CW-1:0]          r_k, n_k;
    logic [TAP_CNT_W-1:0]   r_tap_count;
    logic                   r_rd_vld, n_rd_vld;
    logic                   r_mul_vld;
    t_product               r_prod;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic                   r_out_vld, n_out_vld;
    t_sample                r_out_data, n_out_data;

    logic                   in_accept;
    logic                   cfg_write;
    logic [CW-1:0]          taps_used;
    logic                   coef_in_range;
    logic [CW-1:0]          k_inc;
    logic signed [ACC_W-1:0] acc_shifted;
    t_sample                sat_value;

    logic                   coef_we, hist_we;
    logic [AW-1:0]          coef_waddr, hist_waddr;
    logic [DATA_W-1:0]      coef_wdata, hist_wdata;
    logic [DATA_W-1:0]      coef_rdata, hist_rdata;

    assign in_accept = i_valid && o_ready;
    assign o_ready   = (r_state == ST_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // Register read-back.
    assign prdata = (paddr[2] == REG_TAP_COUNT) ?
                    {{(32-TAP_CNT_W){1'b0}}, r_tap_count} : 32'd0;

    // Taps in use, limited to the store depth.
    assign taps_used = (32'(r_tap_count) > MAX_TAPS) ? CW'(MAX_TAPS) : CW'(r_tap_count);
    assign coef_in_range = (32'(i_coef_index) < MAX_TAPS);
    assign k_inc = r_k + CW'(1);

    // Floor shift of the accumulator and saturation to 16 bits.
    assign acc_shifted = r_acc >>> FRAC_BITS;
    always_comb begin
        if (acc_shifted > SAT_MAX) begin
            sat_value = 16'sh7FFF;
        end else if (acc_shifted < SAT_MIN) begin
            sat_value = 16'sh8000;
        end else begin
            sat_value = acc_shifted[DATA_W-1:0];
        end
    end

    // Memory write ports: clearing pass, coefficient load, or sample write.
    always_comb begin
        coef_we    = 1'b0;
        coef_waddr = r_clr;
        coef_wdata = '0;
        hist_we    = 1'b0;
        hist_waddr = r_clr;
        hist_wdata = '0;
        if (r_state == ST_CLEAR) begin
            coef_we = 1'b1;
            hist_we = 1'b1;
        end else if (in_accept) begin
            if (i_req_type == REQ_LOAD_COEF) begin
                coef_we    = coef_in_range;
                coef_waddr = AW'(i_coef_index);
                coef_wdata = i_data_value;
            end else begin
                hist_we    = 1'b1;
                hist_waddr = r_wp;
                hist_wdata = i_data_value;
            end
        end
    end

    fir_conv_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (coef_wdata),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (coef_rdata)
    );

    fir_conv_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (r_pos),
        .o_rdata (hist_rdata)
    );

    // Sequencer: clearing pass, tap loop, pipeline drain and result hand-off.
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_wp       = r_wp;
        n_pos      = r_pos;
        n_k        = r_k;
        n_rd_vld   = 1'b0;
        n_acc      = r_acc;
        n_out_vld  = r_out_vld && !i_ready;
        n_out_data = r_out_data;

        // Accumulate the product that left the multiplier register.
        if (r_mul_vld) begin
            n_acc = r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end

        unique case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept && i_req_type == REQ_SAMPLE) begin
                    n_pos   = r_wp;
                    n_wp    = (r_wp == LAST_ADDR) ? '0 : r_wp + AW'(1);
                    n_k     = '0;
                    n_acc   = '0;
                    n_state = (taps_used == '0) ? ST_DRAIN : ST_MAC;
                end
            end
            ST_MAC: begin
                // One tap read per cycle; the history walks backward through the ring.
                n_rd_vld = 1'b1;
                n_k      = k_inc;
                n_pos    = (r_pos == '0) ? LAST_ADDR : r_pos - AW'(1);
                if (k_inc == taps_used) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_vld && !r_mul_vld) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || i_ready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = sat_value;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_wp        <= '0;
            r_k         <= '0;
            r_rd_vld    <= 1'b0;
            r_mul_vld   <= 1'b0;
            r_out_vld   <= 1'b0;
            r_tap_count <= TAP_CNT_W'(1);
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_wp      <= n_wp;
            r_k       <= n_k;
            r_rd_vld  <= n_rd_vld;
            r_mul_vld <= r_rd_vld;
            r_out_vld <= n_out_vld;
            if (cfg_write && paddr[2] == REG_TAP_COUNT) begin
                r_tap_count <= pwdata[TAP_CNT_W-1:0];
            end
        end
    end

    // Datapath registers: the shared multiplier, accumulator and output beat.
    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_prod     <= $signed(coef_rdata) * $signed(hist_rdata);
        r_acc      <= n_acc;
        r_out_data <= n_out_data;
    end

    assign o_valid           = r_out_vld;
    assign o_filtered_sample = r_out_data;

endmodule

### hdl/fir_conv_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the coefficient store and the sample history.

module fir_conv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/fir_conv_checker.sv
// Port-level checker for the FIR convolution filter, bound to the top level.
// Depends on fir_conv_pkg and on fir_convolution_filter for the bind.

module fir_conv_checker
    import fir_conv_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic                i_req_type,
    input logic                o_valid,
    input logic                i_ready,
    input logic signed [15:0]  o_filtered_sample
);

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output beat survived reset");

    // A sample beat starts processing, so the block is busy in the next cycle.
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_req_type == REQ_SAMPLE) |=> !o_ready)
        else $error("block stayed ready after a sample beat");

    // A coefficient load leaves the block ready and gives no result.
    a_coef_single_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_req_type == REQ_LOAD_COEF) |=> (o_ready && !$rose(o_valid)))
        else $error("coefficient load held the block or produced a result");

    // A new result appears only at the end of a busy period.
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result appeared without a sample being processed");

    // A stalled output beat holds its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_filtered_sample)))
        else $error("stalled output beat changed");

endmodule

bind fir_convolution_filter fir_conv_checker u_fir_conv_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_ready           (o_ready),
    .i_req_type        (i_req_type),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_filtered_sample (o_filtered_sample)
);

### dv/tb_top.sv
// Self-checking testbench for the FIR convolution filter: a table of directed beats, then
// random coefficient loads and samples under several idle and stall patterns.
// Depends on fir_conv_pkg and the fir_convolution_filter RTL.

module tb_top
    import fir_conv_pkg::*;
;

    localparam int MAX_TAPS       = 256;
    localparam logic [2:0] ADDR_TAP_COUNT = 3'(4 * REG_TAP_COUNT);
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int PHASE_BEATS    = 192;
    localparam int DIR_ROWS       = 25;

    typedef enum logic {ROW_BEAT, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [TAP_CNT_W-1:0]   taps;
        logic                   req;
        logic [7:0]             idx;
        logic [DATA_W-1:0]      val;
        logic                   chk;
        logic [DATA_W-1:0]      want;
    } t_dir_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic                 i_req_type = REQ_LOAD_COEF;
    logic [7:0]           i_coef_index = 8'd0;
    logic signed [15:0]   i_data_value = 16'sd0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic signed [15:0]   o_filtered_sample;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = ADDR_TAP_COUNT;
    logic [31:0]          pwdata = 32'd0;
    logic [31:0]          prdata;
    logic                 pready;

    // Predictor state: coefficient store, history ring, write pointer and tap setting.
    t_sample              coef_mem [MAX_TAPS];
    t_sample              hist_mem [MAX_TAPS];
    logic [7:0]           wr_pos;
    logic [TAP_CNT_W-1:0] tap_setting;

    t_sample              pending_outputs [$];
    t_sample              oldest_output;
    int                   mismatch_count = 0;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   cycle_cnt;

    // Directed beats; the expected output is typed in only where it is obvious.
    t_dir_row dir_rows [DIR_ROWS] = '{
        // Cleared history and coefficients give zero.
        '{ROW_BEAT, 9'd0,   REQ_SAMPLE,    8'd0,   16'h1234, 1'b1, 16'h0000},
        '{ROW_BEAT, 9'd0,   REQ_LOAD_COEF, 8'd0,   16'h8000, 1'b0, 16'h0000},
        // Most negative squared saturates high.
        '{ROW_BEAT, 9'd0,   REQ_SAMPLE,    8'd0,   16'h8000, 1'b1, 16'h7FFF},
        '{ROW_BEAT, 9'd0,   REQ_LOAD_COEF, 8'd0,   16'h7FFF, 1'b0, 16'h0000},
        '{ROW_BEAT, 9'd0,   REQ_SAMPLE,    8'd0,   16'h8000, 1'b1, 16'h8001},
        '{ROW_BEAT, 9'd0,   REQ_SAMPLE,    8'd0,   16'h7FFF, 1'b1, 16'h7FFE},
        '{ROW_CFG,  9'd2,   REQ_LOAD_COEF, 8'd0,   16'h0000, 1'b0, 16'h0000},
        '{ROW_BEAT, 9'd0,   REQ_LOAD_COEF, 8'd1,   16'h8000, 1'b0, 16'h0000},
        '{ROW_BEAT, 9'd0,   REQ_LOAD_COEF, 8'd0,   16'h8000, 1'b0, 16'h0000},
        // Two large negative products saturate low.
        '{ROW_BEAT, 9'd0,   REQ_SAMPLE,    8'd0,   16'h7FFF, 1'b1, 16'h8000},
        // Zero taps sum nothing.
        '{ROW_CFG,  9'd0,   REQ_LOAD_COEF, 8'd0,   16'h0000, 1'b0, 16'h0000},
        '{ROW_BEAT, 9'd0,   REQ_SAMPLE,    8'd0,   16'h7FFF, 1'b1, 16'h0000},
        '{ROW_CFG,  9'd1,   REQ_LOAD_COEF, 8'd0,   16'h0000, 1'b0, 16'h0000},
        '{ROW_BEAT, 9'd0,   REQ_LOAD_COEF, 8'd0,   16'h0001, 1'b0, 16'h0000},
        // The shift rounds toward minus infinity.
        '{ROW_BEAT, 9'd0,   REQ_SAMPLE,    8'd0,   16'hFFFF, 1'b1, 16'hFFFF},
        '{ROW_BEAT, 9'd0,   REQ_SAMPLE,    8'd0,   16'h0001, 1'b1, 16'h0000},
        // A tap count above the store size is clamped.
        '{ROW_CFG,  9'd511, REQ_LOAD_COEF, 8'd0,   16'h0000, 1'b0, 16'h0000},
        '{ROW_BEAT, 9'd0,   REQ_LOAD_COEF, 8'd255, 16'h5555, 1'b0, 16'h0000},
        '{ROW_BEAT, 9'd0,   REQ_LOAD_COEF, 8'd128, 16'hFFFF, 1'b0, 16'h0000},
        '{ROW_BEAT, 9'd0,   REQ_SAMPLE,    8'd0,   16'h8000, 1'b0, 16'h0000},
        '{ROW_BEAT, 9'd0,   REQ_SAMPLE,    8'd0,   16'h7FFF, 1'b0, 16'h0000},
        '{ROW_CFG,  9'd256, REQ_LOAD_COEF, 8'd0,   16'h0000, 1'b0, 16'h0000},
        '{ROW_BEAT, 9'd0,   REQ_LOAD_COEF, 8'd170, 16'h2AAA, 1'b0, 16'h0000},
        '{ROW_BEAT, 9'd0,   REQ_SAMPLE,    8'd0,   16'h4000, 1'b0, 16'h0000},
        '{ROW_BEAT, 9'd0,   REQ_SAMPLE,    8'd0,   16'hC000, 1'b0, 16'h0000}
    };

    fir_convolution_filter #(.MAX_TAPS(MAX_TAPS)) i_dut (.*);

    // Clock with a period of four units.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Writes a sample into the history ring and returns the filtered output.
    function automatic t_sample convolve_sample(t_sample s);
        longint acc;
        longint y;
        int     n;
        int     pos;
        hist_mem[wr_pos] = s;
        n = (tap_setting > MAX_TAPS) ? MAX_TAPS : int'(tap_setting);
        acc = 0;
        pos = int'(wr_pos);
        for (int k = 0; k < n; k++) begin
            acc += longint'(coef_mem[k]) * longint'(hist_mem[pos]);
            pos = (pos == 0) ? MAX_TAPS - 1 : pos - 1;
        end
        y = acc >>> FRAC_BITS;
        if (y > 32767) begin
            y = 32767;
        end else if (y < -32768) begin
            y = -32768;
        end
        wr_pos = wr_pos + 8'd1;
        return t_sample'(y[DATA_W-1:0]);
    endfunction

    // Random data value, with the extremes picked now and then.
    function automatic t_sample pick_value();
        if ($urandom_range(7) != 0) begin
            return t_sample'($urandom);
        end
        case ($urandom_range(4))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'sh0001;
        endcase
    endfunction

    // Sends one input beat and records what it should produce.
    task automatic send_beat(logic req, logic [7:0] idx, t_sample val, logic chk,
                             t_sample want);
        t_sample predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_coef_index <= idx;
        i_data_value <= val;
        do @(posedge i_clk); while (!o_ready);
        if (req == REQ_SAMPLE) begin
            predicted = convolve_sample(val);
            pending_outputs.push_back(chk ? want : predicted);
        end else if (idx < MAX_TAPS) begin
            coef_mem[idx] = val;
        end
    endtask

    // Stops sending and waits until the block has returned every result and is idle.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_outputs.size() != 0 || !o_ready) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes the tap count over the configuration port and reads it back.
    task automatic write_tap_count(logic [TAP_CNT_W-1:0] n);
        wait_drained();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_TAP_COUNT;
        pwdata  <= 32'(n);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tap_setting = n;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(n)) begin
            $display("%0t: tap_count readback mismatch, expected %0d, got %0d",
                     $time, n, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Output side: random stalls and a check of every accepted beat.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_outputs.size() == 0) begin
                $display("%0t: unexpected filtered_sample, expected none, got %0d",
                         $time, o_filtered_sample);
                mismatch_count++;
            end else begin
                oldest_output = pending_outputs.pop_front();
                if (o_filtered_sample !== oldest_output) begin
                    $display("%0t: filtered_sample mismatch, expected %0d, got %0d",
                             $time, oldest_output, o_filtered_sample);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    initial begin
        for (cycle_cnt = 0; cycle_cnt < CYCLE_LIMIT; cycle_cnt++) @(posedge i_clk);
        $display("tb_top NOT OK");
        $finish;
    end

    // Stimulus: reset, directed table, then random phases.
    initial begin : stimulus
        logic [TAP_CNT_W-1:0] taps;
        int                   eff;
        logic [7:0]           idx;
        foreach (coef_mem[i]) begin
            coef_mem[i] = '0;
            hist_mem[i] = '0;
        end
        wr_pos      = '0;
        tap_setting = 9'd1;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Covers the clearing pass after reset.
        wait_drained();

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                write_tap_count(dir_rows[r].taps);
            end else begin
                send_beat(dir_rows[r].req, dir_rows[r].idx, dir_rows[r].val,
                          dir_rows[r].chk, dir_rows[r].want);
            end
        end

        // Two phases per idle pattern, each with its own tap count.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: taps = 9'd256;
                1: taps = 9'd5;
                2: taps = 9'd300;
                3: taps = 9'd1;
                4: taps = 9'd255;
                5: taps = 9'($urandom_range(1, 32));
                6: taps = 9'd2;
                default: taps = 9'($urandom_range(0, 511));
            endcase
            write_tap_count(taps);
            case (ph / 2)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            eff = (taps > MAX_TAPS) ? MAX_TAPS : int'(taps);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if ($urandom_range(99) < 25) begin
                    // Loads mostly land on taps that are in use.
                    if (eff == 0 || $urandom_range(3) == 0) begin
                        idx = 8'($urandom_range(255));
                    end else begin
                        idx = 8'($urandom_range(eff - 1));
                    end
                    send_beat(REQ_LOAD_COEF, idx, pick_value(), 1'b0, '0);
                end else begin
                    send_beat(REQ_SAMPLE, 8'($urandom), pick_value(), 1'b0, '0);
                end
                // Now and then hold off until every result is back.
                if ($urandom_range(99) == 0) begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/fir_conv_pkg.sv
hdl/fir_conv_ram.sv
hdl/fir_convolution_filter.sv
hdl/fir_conv_checker.sv
dv/tb_top.sv
